// ----- rtl/imfp_pkg.sv -----
// ============================================================================
// IMU frame parser package
// Shared types and constants for the IMU report frame parser.
// ============================================================================
package imfp_pkg;

    // Frame layout, counted in bytes from the first header byte.
    localparam logic [4:0] FRAME_LEN = 5'd19;
    localparam logic [4:0] HDR_LAST  = 5'd1;
    localparam logic [4:0] PAY_FIRST = 5'd2;
    localparam logic [4:0] SUM_LAST  = 5'd14;
    localparam logic [4:0] CHECK_POS = 5'd18;
    localparam int         PAY_LEN   = 13;
    localparam int         PAY_IDX_W = $clog2(PAY_LEN);

    // Reset value of the header register.
    localparam logic [7:0] HEADER_RESET = 8'hAA;

    // Meaning of the tuser flag on the input channel.
    typedef enum logic {
        FUNC_BYTE = 1'b0,
        FUNC_END  = 1'b1
    } func_t;

    // One input beat after the input register.
    typedef struct packed {
        func_t      func;
        logic [7:0] rx_byte;
    } in_beat_t;

    // Held report values, laid out so that the index sits in the lowest bits.
    typedef struct packed {
        logic signed [15:0] accel_z;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_x;
        logic signed [15:0] roll_cdeg;
        logic signed [15:0] pitch_cdeg;
        logic signed [15:0] yaw_cdeg;
        logic        [7:0]  report_index;
    } report_t;

endpackage

// ----- rtl/imu_frame_parser_unit.sv -----
// ============================================================================
// IMU frame parser
// Checks and unpacks 19-byte IMU reports received one byte per beat.
// ============================================================================
// Usage:
// The s_ channel carries one beat per received byte (s_tuser low, byte in
// s_tdata) or an end-of-burst event (s_tuser high). Bytes 0 and 1 must match
// the header register, bytes 2 to 14 are summed modulo 256 and compared with
// byte 18; bytes after the nineteenth are dropped. Every end event yields one
// beat on the m_ channel: m_tuser is the frame-good flag and m_tdata the
// values of the last good frame (all zero before the first one).
// The cfg_ channel writes the header byte and is always ready; write it only
// while the parser is idle.
// Throughput is one beat per cycle unless an end event waits for the result
// register; a result is presented on the m_ channel once its end event has
// passed the input register and the result register has taken it.
// While the receiver stalls, byte beats keep being taken; an end event waits
// in the input register until the result register is free.
// Reset clears the burst state, the held values and the header to 0xAA.
// ============================================================================
module imu_frame_parser_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,    // rx_byte[7:0]
    input  logic          s_tuser,    // func[0]
    output logic          m_tvalid,
    input  logic          m_tready,
    // report_index[7:0], yaw_cdeg[23:8], pitch_cdeg[39:24], roll_cdeg[55:40],
    // accel_x[71:56], accel_y[87:72], accel_z[103:88]
    output logic [103:0]  m_tdata,
    output logic          m_tuser,    // frame_ok[0]
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_data
);

    logic [7:0]         header_reg;
    logic               beat_valid;
    imfp_pkg::in_beat_t beat;
    logic               beat_take;

    // Header register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= imfp_pkg::HEADER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            header_reg <= cfg_data;
        end
    end

    imfp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take)
    );

    imfp_frame_core u_frame_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .beat_valid   (beat_valid),
        .beat         (beat),
        .beat_take    (beat_take),
        .header_value (header_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

// ----- rtl/imfp_in_stage.sv -----
// ============================================================================
// IMU frame parser input register
// Registers one input beat and releases it when the frame core takes it.
// ============================================================================
module imfp_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // rx_byte[7:0]
    input  logic                s_tuser,   // func[0]
    output logic                beat_valid,
    output imfp_pkg::in_beat_t  beat,
    input  logic                beat_take
);

    logic               valid_reg;
    logic               valid_next;
    imfp_pkg::in_beat_t beat_reg;
    logic               s_accept;

    // The register is free when empty or when its beat leaves this cycle.
    assign s_tready = !valid_reg || beat_take;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (s_accept) begin
            valid_next = 1'b1;
        end else if (beat_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            beat_reg.func    <= imfp_pkg::func_t'(s_tuser);
            beat_reg.rx_byte <= s_tdata;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

// ----- rtl/imfp_frame_core.sv -----
// ============================================================================
// IMU frame parser core
// Per-byte frame state, frame check at the end of a burst and result register.
// ============================================================================
module imfp_frame_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                beat_valid,
    input  imfp_pkg::in_beat_t  beat,
    output logic                beat_take,
    input  logic [7:0]          header_value,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [103:0]        m_tdata,
    output logic                m_tuser
);

    logic [4:0]                byte_count_reg,  byte_count_next;
    logic                      header_good_reg, header_good_next;
    logic [7:0]                running_sum_reg, running_sum_next;
    logic [7:0]                check_byte_reg,  check_byte_next;
    imfp_pkg::report_t         good_reg,        good_next;
    logic                      m_valid_reg,     m_valid_next;
    logic                      frame_ok_reg,    frame_ok_next;
    logic [7:0]                pending_reg [imfp_pkg::PAY_LEN];
    logic                      pend_we;
    logic [imfp_pkg::PAY_IDX_W-1:0] pend_idx;
    logic                      out_free;
    logic                      take_byte;
    logic                      take_end;
    logic                      frame_ok;

    // Bytes are always taken; an end event needs a free result register.
    assign out_free  = !m_valid_reg || m_tready;
    assign beat_take = beat_valid && ((beat.func == imfp_pkg::FUNC_BYTE) || out_free);
    assign take_byte = beat_take && (beat.func == imfp_pkg::FUNC_BYTE);
    assign take_end  = beat_take && (beat.func == imfp_pkg::FUNC_END);

    // A frame passes with exactly nineteen bytes counted, both headers and the sum.
    assign frame_ok = (byte_count_reg == imfp_pkg::FRAME_LEN) && header_good_reg &&
                      (running_sum_reg == check_byte_reg);

    assign pend_idx = imfp_pkg::PAY_IDX_W'(byte_count_reg - imfp_pkg::PAY_FIRST);

    // Burst state and held values.
    always_comb begin
        byte_count_next  = byte_count_reg;
        header_good_next = header_good_reg;
        running_sum_next = running_sum_reg;
        check_byte_next  = check_byte_reg;
        good_next        = good_reg;
        pend_we          = 1'b0;
        if (take_byte && (byte_count_reg < imfp_pkg::FRAME_LEN)) begin
            if (byte_count_reg <= imfp_pkg::HDR_LAST) begin
                if (beat.rx_byte != header_value) begin
                    header_good_next = 1'b0;
                end
            end else if (byte_count_reg <= imfp_pkg::SUM_LAST) begin
                pend_we          = 1'b1;
                running_sum_next = running_sum_reg + beat.rx_byte;
            end else if (byte_count_reg == imfp_pkg::CHECK_POS) begin
                check_byte_next = beat.rx_byte;
            end
            byte_count_next = byte_count_reg + 5'd1;
        end else if (take_end) begin
            if (frame_ok) begin
                good_next.report_index = pending_reg[0];
                good_next.yaw_cdeg     = {pending_reg[2],  pending_reg[1]};
                good_next.pitch_cdeg   = {pending_reg[4],  pending_reg[3]};
                good_next.roll_cdeg    = {pending_reg[6],  pending_reg[5]};
                good_next.accel_x      = {pending_reg[8],  pending_reg[7]};
                good_next.accel_y      = {pending_reg[10], pending_reg[9]};
                good_next.accel_z      = {pending_reg[12], pending_reg[11]};
            end
            byte_count_next  = 5'd0;
            header_good_next = 1'b1;
            running_sum_next = 8'd0;
            check_byte_next  = 8'd0;
        end
    end

    // Result register: the held values double as the result data.
    always_comb begin
        m_valid_next  = m_valid_reg;
        frame_ok_next = frame_ok_reg;
        if (take_end) begin
            m_valid_next  = 1'b1;
            frame_ok_next = frame_ok;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg  <= 5'd0;
            header_good_reg <= 1'b1;
            running_sum_reg <= 8'd0;
            check_byte_reg  <= 8'd0;
            good_reg        <= '0;
            m_valid_reg     <= 1'b0;
            frame_ok_reg    <= 1'b0;
        end else begin
            byte_count_reg  <= byte_count_next;
            header_good_reg <= header_good_next;
            running_sum_reg <= running_sum_next;
            check_byte_reg  <= check_byte_next;
            good_reg        <= good_next;
            m_valid_reg     <= m_valid_next;
            frame_ok_reg    <= frame_ok_next;
        end
    end

    // Payload bytes of the current burst; only read once all were written.
    always_ff @(posedge aclk) begin
        if (pend_we) begin
            pending_reg[pend_idx] <= beat.rx_byte;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = good_reg;
    assign m_tuser  = frame_ok_reg;

    // The byte counter saturates at the frame length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= imfp_pkg::FRAME_LEN)
        else $error("byte counter ran past the frame length");

    // Every end event leaves a fresh burst and a pending result behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        take_end |=> (byte_count_reg == 5'd0) && header_good_reg && m_valid_reg)
        else $error("end event did not clear the burst or raise a result");

    // A byte beat never creates a result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take_byte && !m_valid_reg) |=> !m_valid_reg)
        else $error("byte beat produced a result");

    // Held values change only on a frame that passed its checks.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(take_end && frame_ok) |=> $stable(good_reg))
        else $error("held values changed without a good frame");

endmodule

// ----- dv/tb_imu_frame_parser_unit.sv -----
`timescale 1ns / 100ps
// ============================================================================
// IMU frame parser testbench
// Feeds byte and end-of-burst beats to the parser and checks every result
// beat against a cycle-free model of the frame checks and held values. The
// run covers a directed opening, then random bursts that are mostly
// well-formed, with broken headers, bad checksums, short, long and noise
// bursts mixed in. Each phase uses its own header byte and idling pattern.
// ============================================================================
module tb_imu_frame_parser_unit;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int IDLE_GAP      = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_BEATS   = 115;
    localparam int PHASE_BURSTS  = 5;
    localparam int MAX_EXTRA     = 6;
    localparam int MAX_NOISE     = 24;

    // Shapes of random burst.
    typedef enum int {
        BURST_GOOD,
        BURST_LONG,
        BURST_BAD_HDR0,
        BURST_BAD_HDR1,
        BURST_BAD_SUM,
        BURST_SHORT,
        BURST_NOISE
    } burst_kind_t;

    // One expected result beat.
    typedef struct packed {
        logic              ok;
        imfp_pkg::report_t vals;
    } frame_result_t;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [7:0]    s_tdata   = '0;
    logic          s_tuser   = 1'b0;
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [103:0]  m_tdata;
    logic          m_tuser;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [7:0]    cfg_data  = '0;

    // Model state of the parser.
    logic [7:0]        header_byte = imfp_pkg::HEADER_RESET;
    logic [4:0]        byte_cnt    = '0;
    logic              hdr_match   = 1'b1;
    logic [7:0]        run_sum     = '0;
    logic [7:0]        chk_byte    = '0;
    logic [7:0]        payload [imfp_pkg::PAY_LEN];
    imfp_pkg::report_t held        = '0;

    imfp_pkg::in_beat_t beat_q [$];
    frame_result_t      report_q [$];
    imfp_pkg::in_beat_t cur_beat;
    int            beats_left     = 0;
    int            beats_queued   = 0;
    int            error_count    = 0;
    int            cycle_count    = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    logic          hold_sender    = 1'b0;

    imu_frame_parser_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Cycle counter with a hard stop.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        error_count++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            flag_error($sformatf("%s got 0x%04h, expected 0x%04h", name, got, want));
    endtask

    // Advance the model by one accepted input beat.
    task automatic parse_beat(input imfp_pkg::in_beat_t beat);
        frame_result_t res;
        logic [4:0]    pos;
        beats_left--;
        if (beat.func == imfp_pkg::FUNC_BYTE) begin
            pos = byte_cnt;
            // Bytes past the end of the frame are dropped.
            if (pos < imfp_pkg::FRAME_LEN) begin
                if (pos <= imfp_pkg::HDR_LAST) begin
                    if (beat.rx_byte != header_byte)
                        hdr_match = 1'b0;
                end else if (pos <= imfp_pkg::SUM_LAST) begin
                    payload[pos - imfp_pkg::PAY_FIRST] = beat.rx_byte;
                    run_sum = run_sum + beat.rx_byte;
                end else if (pos == imfp_pkg::CHECK_POS) begin
                    chk_byte = beat.rx_byte;
                end
                byte_cnt = pos + 5'd1;
            end
        end else begin
            res.ok = (byte_cnt == imfp_pkg::FRAME_LEN) && hdr_match &&
                     (run_sum == chk_byte);
            if (res.ok) begin
                held.report_index = payload[0];
                held.yaw_cdeg     = {payload[2],  payload[1]};
                held.pitch_cdeg   = {payload[4],  payload[3]};
                held.roll_cdeg    = {payload[6],  payload[5]};
                held.accel_x      = {payload[8],  payload[7]};
                held.accel_y      = {payload[10], payload[9]};
                held.accel_z      = {payload[12], payload[11]};
            end
            res.vals = held;
            report_q.push_back(res);
            byte_cnt  = '0;
            hdr_match = 1'b1;
            run_sum   = '0;
            chk_byte  = '0;
        end
    endtask

    // Input driver: presents queued beats, with random gaps and holds.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                parse_beat(cur_beat);
            if (!s_tvalid || s_tready) begin
                if (beat_q.size() != 0 && !hold_sender &&
                    $urandom_range(99) >= send_idle_pct) begin
                    cur_beat = beat_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_beat.rx_byte;
                    s_tuser  <= cur_beat.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random back-pressure and field-by-field comparison.
    always @(posedge aclk) begin
        frame_result_t     want;
        imfp_pkg::report_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = imfp_pkg::report_t'(m_tdata);
                if (report_q.size() == 0) begin
                    flag_error("result beat with no expected result waiting");
                end else begin
                    want = report_q.pop_front();
                    check_field("frame_ok", 16'(m_tuser), 16'(want.ok));
                    check_field("report_index", 16'(got.report_index),
                                16'(want.vals.report_index));
                    check_field("yaw_cdeg", got.yaw_cdeg, want.vals.yaw_cdeg);
                    check_field("pitch_cdeg", got.pitch_cdeg, want.vals.pitch_cdeg);
                    check_field("roll_cdeg", got.roll_cdeg, want.vals.roll_cdeg);
                    check_field("accel_x", got.accel_x, want.vals.accel_x);
                    check_field("accel_y", got.accel_y, want.vals.accel_y);
                    check_field("accel_z", got.accel_z, want.vals.accel_z);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_beat(input imfp_pkg::func_t f, input logic [7:0] b);
        imfp_pkg::in_beat_t beat;
        beat.func    = f;
        beat.rx_byte = b;
        beat_q.push_back(beat);
        beats_left++;
        beats_queued++;
    endtask

    // The rx_byte of an end event is ignored, so it carries random bits.
    task automatic push_end();
        push_beat(imfp_pkg::FUNC_END, 8'($urandom_range(255)));
    endtask

    // Queue one random burst of the given shape, closed by an end event.
    task automatic queue_burst(input burst_kind_t kind);
        logic [7:0] frame [19];
        logic [7:0] csum;
        int         len;
        csum = '0;
        frame[0] = header_byte;
        frame[1] = header_byte;
        for (int i = 2; i < 19; i++)
            frame[i] = 8'($urandom_range(255));
        for (int i = 2; i <= 14; i++)
            csum = csum + frame[i];
        frame[18] = csum;
        len = 19;
        case (kind)
            BURST_BAD_HDR0: frame[0]  = header_byte ^ 8'($urandom_range(1, 255));
            BURST_BAD_HDR1: frame[1]  = header_byte ^ 8'($urandom_range(1, 255));
            BURST_BAD_SUM:  frame[18] = csum ^ 8'($urandom_range(1, 255));
            BURST_SHORT:    len = $urandom_range(0, 18);
            default: ;
        endcase
        if (kind == BURST_NOISE) begin
            len = $urandom_range(0, MAX_NOISE);
            for (int i = 0; i < len; i++)
                push_beat(imfp_pkg::FUNC_BYTE, 8'($urandom_range(255)));
        end else begin
            for (int i = 0; i < len; i++)
                push_beat(imfp_pkg::FUNC_BYTE, frame[i]);
            // Trailing bytes that the parser must discard.
            if (kind == BURST_LONG) begin
                len = $urandom_range(1, MAX_EXTRA);
                for (int i = 0; i < len; i++)
                    push_beat(imfp_pkg::FUNC_BYTE, 8'($urandom_range(255)));
            end
        end
        push_end();
    endtask

    // Wait until all beats are taken and all results seen, then leave an idle gap.
    task automatic wait_idle();
        while (beats_left != 0 || report_q.size() != 0)
            @(posedge aclk);
        repeat (IDLE_GAP) @(posedge aclk);
    endtask

    task automatic write_header(input logic [7:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid   <= 1'b0;
        header_byte = value;
    endtask

    // One random phase: header write, idling pattern, then mostly good bursts.
    task automatic run_phase(input logic [7:0] hdr, input int send_pct,
                             input int stall_pct, input logic pause_mid);
        int start_beats;
        int bursts;
        int r;
        write_header(hdr);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        start_beats    = beats_queued;
        bursts         = 0;
        while (beats_queued - start_beats < PHASE_BEATS || bursts < PHASE_BURSTS) begin
            r = $urandom_range(99);
            if (r < 50)      queue_burst(BURST_GOOD);
            else if (r < 62) queue_burst(BURST_LONG);
            else if (r < 70) queue_burst(BURST_BAD_HDR0);
            else if (r < 77) queue_burst(BURST_BAD_HDR1);
            else if (r < 86) queue_burst(BURST_BAD_SUM);
            else if (r < 94) queue_burst(BURST_SHORT);
            else             queue_burst(BURST_NOISE);
            bursts++;
        end
        // Halfway through, hold the sender until the receiver has caught up.
        if (pause_mid) begin
            while (beats_left > (beats_queued - start_beats) / 2)
                @(posedge aclk);
            hold_sender = 1'b1;
            while (report_q.size() != 0)
                @(posedge aclk);
            hold_sender = 1'b0;
        end
        wait_idle();
    endtask

    // Reset, directed opening, random phases and the final verdict.
    initial begin
        logic [7:0] dir_frame [19];
        logic [7:0] csum;
        dir_frame = '{8'hAA, 8'hAA, 8'hFF, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'h00,
                      8'h00, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h80, 8'hFF, 8'h55,
                      8'h00, 8'hFF, 8'h00};
        csum = '0;
        for (int i = 2; i <= 14; i++)
            csum = csum + dir_frame[i];
        dir_frame[18] = csum;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty burst, then a good frame with extreme words and excess bytes,
        // then a short burst that must keep the held values.
        push_end();
        for (int i = 0; i < 19; i++)
            push_beat(imfp_pkg::FUNC_BYTE, dir_frame[i]);
        push_beat(imfp_pkg::FUNC_BYTE, 8'h00);
        push_beat(imfp_pkg::FUNC_BYTE, 8'hFF);
        push_end();
        push_beat(imfp_pkg::FUNC_BYTE, imfp_pkg::HEADER_RESET);
        push_beat(imfp_pkg::FUNC_BYTE, imfp_pkg::HEADER_RESET);
        push_end();
        wait_idle();

        run_phase(8'h00, 87, 0, 1'b0);
        run_phase(8'hFF, 0, 87, 1'b0);
        run_phase(8'($urandom_range(255)), 19, 19, 1'b0);
        run_phase(imfp_pkg::HEADER_RESET, 0, 0, 1'b1);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
